[design/bfh_pkg.sv]
// Package for the back/forward id history block.
// Holds field widths, operation codes and the controller/datapath interface structs.
// No dependencies.
package bfh_pkg;

  // Field widths of the stream payloads.
  localparam int FuncW    = 2;
  localparam int IdW      = 31;
  localparam int SIdW     = 32;
  localparam int CountW   = 8;
  localparam int InDataW  = 64;
  localparam int OutDataW = 48;

  // Operation codes carried on the input tuser.
  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FOLLOW = 2'd1;
  localparam logic [FuncW-1:0] FUNC_BACK   = 2'd2;
  localparam logic [FuncW-1:0] FUNC_FWD    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic add_first;  // add the followed id when it qualifies
    logic add_new;    // add the new id
    logic step;       // move the cursor back or forward
    logic load_cur;   // take the cursor id from the store read port
    logic push;       // load the result into the output register
  } bfh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } bfh_status_t;

endpackage

[design/back_forward_id_history_top.sv]
// Top level of the back/forward id history of entity ids.
// Joins bfh_ctrl and bfh_datapath; depends on bfh_pkg.
//
//  Channel  Dir  Payload
//  s_axis   in   tuser: func[1:0]; tdata: new_id[30:0], followed_id[62:31]
//  m_axis   out  tdata: cursor_id[31:0], entry_count[39:32], moved[40],
//                       need_new_pick[41]
//
// One request at a time. The result is loaded into the output register from
// state DONE, reached through ADD for add, FIRST and ADD for follow, and STEP
// and LOAD for back or forward, LOAD taking the registered read of the id
// store for a cursor step. The next request is taken in the cycle after the
// result is loaded.
// A result waiting in the output register does not block the next request;
// the following result waits until the output register is taken.
// Reset clears the pointers, count and cursor; the id store needs no clearing.
module back_forward_id_history_top #(
  parameter int HISTORY_DEPTH = 200
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bfh_pkg::InDataW-1:0]  s_axis_tdata,  // new_id, followed_id, zero pad
  input  logic [bfh_pkg::FuncW-1:0]    s_axis_tuser,  // func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bfh_pkg::OutDataW-1:0] m_axis_tdata   // cursor_id, entry_count, moved,
                                                      // need_new_pick, zero pad
);
  import bfh_pkg::*;

  bfh_cmd_t    cmd;
  bfh_status_t status;

  // Controller.
  bfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  bfh_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_func_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[design/bfh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the id store of the history; no dependencies.
module bfh_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 200
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/bfh_ctrl.sv]
// Controller state machine of the back/forward id history.
// Sequences add, follow and cursor steps; depends on bfh_pkg.
module bfh_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [bfh_pkg::FuncW-1:0]  in_func_i,
  output logic                       in_ready_o,
  input  bfh_pkg::bfh_status_t       status_i,
  output bfh_pkg::bfh_cmd_t          cmd_o
);
  import bfh_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_func_i)
            FUNC_ADD:    state_d = ST_ADD;
            FUNC_FOLLOW: state_d = ST_FIRST;
            default:     state_d = ST_STEP;
          endcase
        end
      end
      ST_FIRST: begin
        cmd_o.add_first = 1'b1;
        state_d         = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_new = 1'b1;
        state_d       = ST_DONE;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_cur = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/bfh_datapath.sv]
// Datapath of the back/forward id history: ring pointers, cursor, id store
// and output register. Depends on bfh_pkg and bfh_ram.
module bfh_datapath #(
  parameter int HISTORY_DEPTH = 200
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfh_pkg::bfh_cmd_t            cmd_i,
  output bfh_pkg::bfh_status_t         status_o,
  input  logic [bfh_pkg::FuncW-1:0]    in_func_i,
  input  logic [bfh_pkg::InDataW-1:0]  in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bfh_pkg::OutDataW-1:0] out_data_o
);
  import bfh_pkg::*;

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);

  // Slot that lies back entries behind newest, modulo the depth (back below depth).
  function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] newest,
                                              input logic [CW-1:0] back);
    logic [CW:0] t;
    t = (CW + 1)'(newest) - {1'b0, back};
    if ((CW + 1)'(newest) < {1'b0, back}) begin
      t = t + DEPTH_X;
    end
    return t[SW-1:0];
  endfunction

  // Request registers.
  logic [FuncW-1:0] op_q;
  logic [IdW-1:0]   new_id_q;
  logic [SIdW-1:0]  followed_q;

  // History state.
  logic [SW-1:0]  newest_q;
  logic [CW-1:0]  held_q;
  logic [CW-1:0]  cb_q;
  logic [IdW-1:0] cur_q;
  logic           moved_q, pick_q;

  // Output register.
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  // Store ports.
  logic           ram_we;
  logic [SW-1:0]  ram_raddr;
  logic [IdW-1:0] ram_rdata;

  // Add unit signals.
  logic           first_ok, do_add, dup;
  logic [IdW-1:0] add_id;
  logic [CW-1:0]  held_a, held_n;
  logic [SW-1:0]  newest_a, newest_n;

  // Step unit signals.
  logic [CW-1:0] cb_step;
  logic          step_moved, step_pick;

  // Output word fields.
  logic [SIdW-1:0]      cursor_word;
  logic [CountW+CW-1:0] count_ext;

  // The followed id is added only if present and not already under the cursor.
  assign first_ok = !followed_q[SIdW-1] &&
                    ((held_q == '0) || (followed_q[IdW-1:0] != cur_q));
  assign do_add   = (cmd_i.add_first && first_ok) || cmd_i.add_new;
  assign add_id   = cmd_i.add_first ? followed_q[IdW-1:0] : new_id_q;

  // Add: drop entries newer than the cursor, then append unless duplicate.
  // After the drop the newest entry is the old cursor entry, held in cur_q.
  always_comb begin
    held_a   = held_q;
    newest_a = newest_q;
    if (cb_q != '0) begin
      if (cb_q >= held_q) begin
        held_a = '0;
      end else begin
        held_a   = held_q - cb_q;
        newest_a = slot_back(newest_q, cb_q);
      end
    end
    dup      = (held_a != '0) && (cur_q == add_id);
    newest_n = newest_a;
    held_n   = held_a;
    if (!dup) begin
      if (held_a == '0) begin
        newest_n = '0;
      end else if (newest_a == LAST_SLOT) begin
        newest_n = '0;
      end else begin
        newest_n = newest_a + SW'(1);
      end
      if (held_a != DEPTH_C) begin
        held_n = held_a + CW'(1);
      end
    end
  end

  assign ram_we = do_add && !dup;

  // Step: move the cursor back or forward within the held entries.
  always_comb begin
    cb_step    = cb_q;
    step_moved = 1'b0;
    step_pick  = 1'b0;
    if (op_q == FUNC_BACK) begin
      if ((held_q != '0) && (({1'b0, cb_q} + (CW + 1)'(1)) < {1'b0, held_q})) begin
        cb_step    = cb_q + CW'(1);
        step_moved = 1'b1;
      end
    end else begin
      if ((held_q == '0) || (cb_q == '0)) begin
        step_pick = 1'b1;
      end else begin
        cb_step    = cb_q - CW'(1);
        step_moved = 1'b1;
      end
    end
  end

  assign ram_raddr = slot_back(newest_q, cb_step);

  bfh_ram #(
    .WIDTH (IdW),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (newest_n),
    .wdata_i (add_id),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state of the history and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q  <= '0;
      held_q    <= '0;
      cb_q      <= '0;
      moved_q   <= 1'b0;
      pick_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        moved_q <= 1'b0;
        pick_q  <= 1'b0;
      end
      if (do_add) begin
        newest_q <= newest_n;
        held_q   <= held_n;
        cb_q     <= '0;
      end
      if (cmd_i.step) begin
        cb_q    <= cb_step;
        moved_q <= step_moved;
        pick_q  <= step_pick;
      end
      if (cmd_i.push) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign cursor_word = (held_q == '0) ? '1 : {1'b0, cur_q};
  assign count_ext   = {{CountW{1'b0}}, held_q};

  // Payload registers: request, cursor id and result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_func_i;
      new_id_q   <= in_data_i[IdW-1:0];
      followed_q <= in_data_i[IdW+SIdW-1:IdW];
    end
    if (do_add && !dup) begin
      cur_q <= add_id;
    end else if (cmd_i.load_cur) begin
      cur_q <= ram_rdata;
    end
    if (cmd_i.push) begin
      m_data_q <= {6'b0, pick_q, moved_q, count_ext[CountW-1:0], cursor_word};
    end
  end

  assign status_o.out_free = !m_valid_q || out_ready_i;
  assign out_valid_o       = m_valid_q;
  assign out_data_o        = m_data_q;

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= DEPTH_C)
    else $error("held count exceeds the history depth");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cb_q == '0) || (cb_q < held_q))
    else $error("cursor stands outside the held entries");

  a_add_resets_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_add |=> (cb_q == '0))
    else $error("add did not return the cursor to the newest entry");

  a_step_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> !(moved_q && pick_q))
    else $error("step reported both a move and a new pick");
`endif

endmodule
